/* hdl/vtp_pkg.sv */
// vtp_pkg: sizes, mixing constants, entry layouts and helpers of the value predictor
// used by vtp_hash, vtage_value_predictor and the test files; no dependencies
package vtp_pkg;

	localparam int BASE_DEPTH   = 1024;
	localparam int NUM_BANKS    = 4;
	localparam int BANK_ENTRIES = 1024;
	localparam int TAG_WIDTH    = 12;
	localparam int CONF_WIDTH   = 3;

	localparam int BASE_IDX_W = $clog2(BASE_DEPTH);
	localparam int BANK_IDX_W = $clog2(BANK_ENTRIES);
	localparam int BANK_SEL_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int TAG_DEPTH  = NUM_BANKS * BANK_ENTRIES;
	localparam int TAG_ADDR_W = $clog2(TAG_DEPTH);
	localparam int CLR_DEPTH  = (TAG_DEPTH > BASE_DEPTH) ? TAG_DEPTH : BASE_DEPTH;
	localparam int CLR_W      = $clog2(CLR_DEPTH);
	localparam int NUM_JOBS   = 2 * NUM_BANKS + 1;
	localparam int JOB_W      = $clog2(NUM_JOBS);

	localparam logic [63:0] MIX1   = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX2   = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam int          SHIFT  = 33;

	localparam logic [CONF_WIDTH-1:0] CONF_TOP   = '1;
	localparam logic [1:0]            USEFUL_MAX = 2'd3;
	localparam logic signed [3:0]     PROV_NONE  = -4'sd1;

	typedef enum logic [1:0] {
		MODE_PREDICT    = 2'd0,
		MODE_TRAIN      = 2'd1,
		MODE_TRAIN_PROV = 2'd2,
		MODE_PATH       = 2'd3
	} mode_t;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_HIST_LEN  = 1'b1;

	typedef struct packed {
		logic                  valid;
		logic [CONF_WIDTH-1:0] conf;
		logic [63:0]           data;
	} base_ent_t;

	typedef struct packed {
		logic                  valid;
		logic [TAG_WIDTH-1:0]  tag;
		logic [63:0]           data;
		logic [CONF_WIDTH-1:0] conf;
		logic [1:0]            useful;
	} tag_ent_t;

	typedef struct packed {
		logic        start;
		logic [63:0] x;
	} hash_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] y;
	} hash_rsp_t;

	function automatic logic [63:0] hist_mask(input logic [BANK_SEL_W-1:0] bank);
		int len;
		len = 8 << bank;
		if (len >= 64)
			return '1;
		return (64'd1 << len) - 64'd1;
	endfunction

	function automatic logic [CONF_WIDTH-1:0] conf_up(input logic [CONF_WIDTH-1:0] c);
		return (c == CONF_TOP) ? c : c + 1'b1;
	endfunction

	function automatic logic [CONF_WIDTH-1:0] conf_down(input logic [CONF_WIDTH-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

endpackage

/* hdl/vtp_ram.sv */
// vtp_ram: generic single-write, single-read synchronous memory, registered read
// no dependencies
module vtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* hdl/vtp_hash.sv */
// vtp_hash: iterative multiply-xor scrambler built from 32x32 partial products; a new start restarts it
// depends on vtp_pkg
module vtp_hash (
	input  logic              clk,
	input  logic              arst_n,
	input  vtp_pkg::hash_req_t req,
	output vtp_pkg::hash_rsp_t rsp
);
	import vtp_pkg::*;

	logic [63:0] a_q, b_q, acc_q, prod_q, y_q;
	logic [1:0]  step_q;
	logic        pass_q, run_q, done_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] sum;

	// low 64 bits of a*b: lo*lo plus both cross terms shifted up
	assign mul_a = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign mul_b = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	assign sum   = acc_q + {prod_q[31:0], 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			pass_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				pass_q <= 1'b0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					pass_q <= 1'b1;
					if (pass_q) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.x ^ (req.x >> SHIFT);
			b_q <= MIX1;
		end else if (run_q) begin
			case (step_q)
				2'd0: prod_q <= mul_a * mul_b;
				2'd1: begin
					acc_q  <= prod_q;
					prod_q <= mul_a * mul_b;
				end
				2'd2: begin
					acc_q  <= sum;
					prod_q <= mul_a * mul_b;
				end
				default: begin
					if (pass_q)
						y_q <= sum ^ (sum >> SHIFT);
					else begin
						a_q <= sum ^ (sum >> SHIFT);
						b_q <= MIX2;
					end
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.y    = y_q;

endmodule

/* hdl/vtage_value_predictor.sv */
// vtage_value_predictor: top level, sequencer, tables and configuration registers
// depends on vtp_pkg, vtp_hash, vtp_ram
//
//  channel   handshake                      payload
//  input     start, busy (accept start&!busy) mode pc actual_value was_correct
//                                            provider_in branch_taken
//  result    result_valid, one-cycle strobe available confident predicted_value
//                                            provider_out
//  config    apb psel penable pwrite pready paddr pwdata prdata
//
// after reset a clearing pass over every table address empties both tables; busy stays high
// a predict, train or train-provider transaction runs nine scrambles through the
//   shared hash unit, then one table read per probed entry and, for the two trains,
//   a write-back
// path history updates and ignored provider trains pass through S_FINISH back to idle
// the receiver cannot stall: a result is shown for one cycle only
module vtage_value_predictor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [63:0]        pc,
	input  logic [63:0]        actual_value,
	input  logic               was_correct,
	input  logic signed [3:0]  provider_in,
	input  logic               branch_taken,
	output logic               result_valid,
	output logic               available,
	output logic               confident,
	output logic [63:0]        predicted_value,
	output logic signed [3:0]  provider_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import vtp_pkg::*;

	localparam int CMP_W = (CONF_WIDTH > 3) ? CONF_WIDTH : 3;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FINISH, S_HASH_GO, S_HASH_WAIT,
		S_BASE_RD, S_BASE_CHK, S_TAG_RD, S_TAG_CHK
	} state_t;

	state_t state_q;

	// configuration
	logic [2:0] thr_q;
	logic [6:0] hlen_q;

	// latched transaction
	mode_t             mode_q;
	logic [63:0]       pc_q, val_q, path_q;
	logic              corr_q;
	logic signed [3:0] prov_q;

	// hash results
	logic [JOB_W-1:0]      job_q;
	logic [BASE_IDX_W-1:0] base_idx_q;
	logic [BANK_IDX_W-1:0] slot_q [NUM_BANKS];
	logic [TAG_WIDTH-1:0]  tag_q  [NUM_BANKS];
	logic [BANK_SEL_W-1:0] bank_q;
	logic [CLR_W-1:0]      clr_q;

	hash_req_t hreq;
	hash_rsp_t hrsp;

	logic [63:0]           pcs, hist, path_nxt;
	logic [BANK_SEL_W-1:0] job_bank;
	logic [JOB_W-1:0]      job_m1;

	logic                  base_we, tag_we;
	logic [BASE_IDX_W-1:0] base_waddr;
	logic [TAG_ADDR_W-1:0] tag_addr, tag_waddr;
	base_ent_t             base_rd, base_wr;
	tag_ent_t              tag_rd, tag_wr, tag_fill;
	logic                  tag_match, accept, cfg_wr;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// hash job select: job 0 base index, odd jobs bank index, even jobs bank tag
	assign pcs      = pc_q >> 2;
	assign job_m1   = job_q - 1'b1;
	assign job_bank = BANK_SEL_W'(job_m1 >> 1);
	assign hist     = path_q & hist_mask(job_bank);

	always_comb begin
		hreq.start = (state_q == S_HASH_GO);
		if (job_q == '0)
			hreq.x = pcs;
		else if (job_q[0])
			hreq.x = hist ^ (GOLDEN + 64'(job_bank));
		else
			hreq.x = pcs ^ (hist << 1) ^ 64'(job_bank);
	end

	vtp_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	// path history shift, masked to the configured length
	always_comb begin
		path_nxt = {path_q[62:0], pc[2] ^ branch_taken};
		if (hlen_q < 7'd64)
			path_nxt = path_nxt & ((64'd1 << hlen_q) - 64'd1);
	end

	// tables: one transaction at a time, so a read never overlaps a pending write
	logic [$bits(base_ent_t)-1:0] base_rdata;
	logic [$bits(tag_ent_t)-1:0]  tag_rdata;

	assign base_rd  = base_ent_t'(base_rdata);
	assign tag_rd   = tag_ent_t'(tag_rdata);
	assign tag_addr = (TAG_ADDR_W'(bank_q) << BANK_IDX_W) | TAG_ADDR_W'(slot_q[bank_q]);

	vtp_ram #(.WIDTH($bits(base_ent_t)), .DEPTH(BASE_DEPTH)) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (base_waddr),
		.wdata (base_wr),
		.raddr (base_idx_q),
		.rdata (base_rdata)
	);

	vtp_ram #(.WIDTH($bits(tag_ent_t)), .DEPTH(TAG_DEPTH)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wr),
		.raddr (tag_addr),
		.rdata (tag_rdata)
	);

	assign tag_match = tag_rd.valid && (tag_rd.tag == tag_q[bank_q]);

	// base entry update
	always_comb begin
		base_wr       = base_rd;
		base_wr.valid = 1'b1;
		base_wr.data  = val_q;
		if (!base_rd.valid)
			base_wr.conf = '0;
		else if (mode_q == MODE_TRAIN)
			base_wr.conf = (base_rd.data == val_q) ? conf_up(base_rd.conf)
			                                       : conf_down(base_rd.conf);
		else
			base_wr.conf = corr_q ? conf_up(base_rd.conf) : conf_down(base_rd.conf);
		base_we    = (state_q == S_BASE_CHK) && (mode_q != MODE_PREDICT);
		base_waddr = base_idx_q;
		if (state_q == S_CLEAR) begin
			base_wr    = '0;
			base_we    = 1'b1;
			base_waddr = clr_q[BASE_IDX_W-1:0];
		end
	end

	// tagged entry update
	always_comb begin
		tag_fill        = '0;
		tag_fill.valid  = 1'b1;
		tag_fill.tag    = tag_q[bank_q];
		tag_fill.data   = val_q;
		tag_wr          = tag_rd;
		tag_wr.data     = val_q;
		tag_we          = 1'b0;
		if (mode_q == MODE_TRAIN) begin
			tag_wr.conf = (tag_rd.data == val_q) ? conf_up(tag_rd.conf)
			                                     : conf_down(tag_rd.conf);
			tag_we      = (state_q == S_TAG_CHK) && (!tag_rd.valid || tag_match);
		end else begin
			if (corr_q) begin
				tag_wr.conf   = conf_up(tag_rd.conf);
				tag_wr.useful = (tag_rd.useful == USEFUL_MAX) ? tag_rd.useful
				                                              : tag_rd.useful + 2'd1;
			end else begin
				tag_wr.conf   = conf_down(tag_rd.conf);
				tag_wr.useful = '0;
			end
			tag_we = (state_q == S_TAG_CHK) && (mode_q == MODE_TRAIN_PROV);
		end
		if (!tag_match)
			tag_wr = tag_fill;
		tag_waddr = tag_addr;
		if (state_q == S_CLEAR) begin
			tag_wr    = '0;
			tag_we    = 1'b1;
			tag_waddr = clr_q[TAG_ADDR_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= 3'd7;
			hlen_q <= 7'd64;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_HIST_LEN)
				hlen_q <= pwdata[6:0];
			else
				thr_q <= pwdata[2:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_THRESHOLD)
				prdata = {29'd0, thr_q};
			else
				prdata = {25'd0, hlen_q};
		end
	end

	// transaction payload latch and hash result capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			pc_q   <= pc;
			val_q  <= actual_value;
			corr_q <= was_correct;
			prov_q <= provider_in;
		end
		if (hrsp.done) begin
			if (job_q == '0)
				base_idx_q <= hrsp.y[BASE_IDX_W-1:0];
			else if (job_q[0])
				slot_q[job_bank] <= pcs[BANK_IDX_W-1:0] ^ hrsp.y[BANK_IDX_W-1:0];
			else
				tag_q[job_bank] <= hrsp.y[TAG_WIDTH-1:0];
		end
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			job_q           <= '0;
			bank_q          <= '0;
			path_q          <= '0;
			result_valid    <= 1'b0;
			available       <= 1'b0;
			confident       <= 1'b0;
			predicted_value <= '0;
			provider_out    <= PROV_NONE;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						job_q <= '0;
						if (mode_t'(mode) == MODE_PATH) begin
							path_q  <= path_nxt;
							state_q <= S_FINISH;
						end else if (mode_t'(mode) == MODE_TRAIN_PROV &&
						             (provider_in < 4'sd0 ||
						              provider_in > $signed(4'(NUM_BANKS))))
							state_q <= S_FINISH;
						else
							state_q <= S_HASH_GO;
					end
				end
				S_FINISH: state_q <= S_IDLE;
				S_HASH_GO: state_q <= S_HASH_WAIT;
				S_HASH_WAIT: begin
					if (hrsp.done) begin
						if (job_q != JOB_W'(NUM_JOBS - 1)) begin
							job_q   <= job_q + 1'b1;
							state_q <= S_HASH_GO;
						end else begin
							case (mode_q)
								MODE_PREDICT: begin
									bank_q  <= BANK_SEL_W'(NUM_BANKS - 1);
									state_q <= S_TAG_RD;
								end
								MODE_TRAIN: state_q <= S_BASE_RD;
								MODE_TRAIN_PROV: begin
									if (prov_q == 4'sd0)
										state_q <= S_BASE_RD;
									else begin
										bank_q  <= BANK_SEL_W'(prov_q - 4'sd1);
										state_q <= S_TAG_RD;
									end
								end
								default: state_q <= S_IDLE;
							endcase
						end
					end
				end
				S_BASE_RD: state_q <= S_BASE_CHK;
				S_BASE_CHK: begin
					if (mode_q == MODE_PREDICT) begin
						result_valid    <= 1'b1;
						available       <= base_rd.valid;
						confident       <= 1'b0;
						predicted_value <= base_rd.valid ? base_rd.data : 64'd0;
						provider_out    <= base_rd.valid ? 4'sd0 : PROV_NONE;
						state_q         <= S_IDLE;
					end else if (mode_q == MODE_TRAIN) begin
						// base written, now search the tagged banks from the longest
						bank_q  <= BANK_SEL_W'(NUM_BANKS - 1);
						state_q <= S_TAG_RD;
					end else
						state_q <= S_IDLE;
				end
				S_TAG_RD: state_q <= S_TAG_CHK;
				S_TAG_CHK: begin
					if (mode_q == MODE_PREDICT) begin
						if (tag_match) begin
							result_valid    <= 1'b1;
							available       <= 1'b1;
							confident       <= CMP_W'(tag_rd.conf) >= CMP_W'(thr_q);
							predicted_value <= tag_rd.data;
							provider_out    <= $signed(4'(bank_q) + 4'd1);
							state_q         <= S_IDLE;
						end else if (bank_q == '0)
							state_q <= S_BASE_RD;
						else begin
							bank_q  <= bank_q - 1'b1;
							state_q <= S_TAG_RD;
						end
					end else if (mode_q == MODE_TRAIN && tag_rd.valid && !tag_match &&
					             bank_q != '0) begin
						bank_q  <= bank_q - 1'b1;
						state_q <= S_TAG_RD;
					end else
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// an accepted transaction always makes the block busy in the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	// a result strobe lasts exactly one cycle
	a_strobe_once: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// a result is delivered as the sequencer returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while busy");

	// no prediction means zero value and no provider
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !available) |->
		(predicted_value == 64'd0 && provider_out == PROV_NONE && !confident))
		else $error("empty prediction carries payload");

endmodule

/* test/vtp_checker.sv */
`timescale 1ns / 100ps
// vtp_checker: watches the input, result and apb channels of the value predictor,
// keeps its own copy of the tables and compares every result; depends on vtp_pkg
module vtp_checker
	import vtp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        mode,
	input  logic [63:0]       pc,
	input  logic [63:0]       actual_value,
	input  logic              was_correct,
	input  logic signed [3:0] provider_in,
	input  logic              branch_taken,
	input  logic              result_valid,
	input  logic              available,
	input  logic              confident,
	input  logic [63:0]       predicted_value,
	input  logic signed [3:0] provider_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output int                errors,
	output int                pending,
	output int                results_seen
);

	localparam logic [2:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
	localparam logic [2:0] ADDR_HIST_LEN  = {REG_HIST_LEN, 2'b00};

	typedef struct packed {
		logic              avail;
		logic              conf;
		logic [63:0]       value;
		logic signed [3:0] prov;
	} lookup_t;

	logic                  base_v [BASE_DEPTH];
	logic [63:0]           base_d [BASE_DEPTH];
	logic [CONF_WIDTH-1:0] base_c [BASE_DEPTH];
	logic                  tag_v  [TAG_DEPTH];
	logic [TAG_WIDTH-1:0]  tag_t  [TAG_DEPTH];
	logic [63:0]           tag_d  [TAG_DEPTH];
	logic [CONF_WIDTH-1:0] tag_c  [TAG_DEPTH];
	logic [1:0]            tag_u  [TAG_DEPTH];
	logic [63:0]           path;
	logic [2:0]            threshold;
	logic [6:0]            hist_len;
	lookup_t               lookups_due[$];

	function automatic logic [63:0] mix64(input logic [63:0] x);
		x = x ^ (x >> SHIFT);
		x = x * MIX1;
		x = x ^ (x >> SHIFT);
		x = x * MIX2;
		x = x ^ (x >> SHIFT);
		return x;
	endfunction

	function automatic logic [63:0] bank_path(input int b);
		int len;
		len = 8 << b;
		if (len >= 64)
			return path;
		return path & ((64'd1 << len) - 64'd1);
	endfunction

	function automatic int base_index(input logic [63:0] a);
		logic [63:0] h;
		h = mix64(a >> 2);
		return int'(h[BASE_IDX_W-1:0]);
	endfunction

	function automatic int bank_index(input logic [63:0] a, input int b);
		logic [63:0] key;
		key = (a >> 2) ^ mix64(bank_path(b) ^ (GOLDEN + 64'(b)));
		return b * BANK_ENTRIES + int'(key[BANK_IDX_W-1:0]);
	endfunction

	function automatic logic [TAG_WIDTH-1:0] bank_tag(input logic [63:0] a, input int b);
		logic [63:0] key;
		key = mix64((a >> 2) ^ (bank_path(b) << 1) ^ 64'(b));
		return key[TAG_WIDTH-1:0];
	endfunction

	function automatic logic [CONF_WIDTH-1:0] sat_up(input logic [CONF_WIDTH-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [CONF_WIDTH-1:0] sat_down(input logic [CONF_WIDTH-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

	task automatic fill_entry(input int s, input logic [TAG_WIDTH-1:0] t, input logic [63:0] v);
		tag_v[s] = 1'b1;
		tag_t[s] = t;
		tag_d[s] = v;
		tag_c[s] = '0;
		tag_u[s] = '0;
	endtask

	function automatic lookup_t lookup(input logic [63:0] a);
		lookup_t r;
		int s;
		int bi;
		r = '{avail: 1'b0, conf: 1'b0, value: 64'd0, prov: PROV_NONE};
		for (int b = NUM_BANKS - 1; b >= 0; b--) begin
			s = bank_index(a, b);
			if (tag_v[s] && tag_t[s] == bank_tag(a, b)) begin
				r.avail = 1'b1;
				r.conf  = (tag_c[s] >= threshold);
				r.value = tag_d[s];
				r.prov  = 4'(b + 1);
				return r;
			end
		end
		bi = base_index(a);
		if (base_v[bi]) begin
			r.avail = 1'b1;
			r.value = base_d[bi];
			r.prov  = 4'sd0;
		end
		return r;
	endfunction

	task automatic learn(input logic [63:0] a, input logic [63:0] v);
		int bi;
		int s;
		logic [TAG_WIDTH-1:0] t;
		bi = base_index(a);
		if (!base_v[bi]) begin
			base_v[bi] = 1'b1;
			base_d[bi] = v;
			base_c[bi] = '0;
		end else if (base_d[bi] == v) begin
			base_c[bi] = sat_up(base_c[bi]);
		end else begin
			base_c[bi] = sat_down(base_c[bi]);
			base_d[bi] = v;
		end
		// longest history first; if no bank is free or matching, nothing changes
		for (int b = NUM_BANKS - 1; b >= 0; b--) begin
			s = bank_index(a, b);
			t = bank_tag(a, b);
			if (!tag_v[s]) begin
				fill_entry(s, t, v);
				return;
			end
			if (tag_t[s] == t) begin
				if (tag_d[s] == v) begin
					tag_c[s] = sat_up(tag_c[s]);
				end else begin
					tag_c[s] = sat_down(tag_c[s]);
					tag_d[s] = v;
				end
				return;
			end
		end
	endtask

	task automatic learn_provider(input logic [63:0] a, input logic [63:0] v, input logic ok,
			input logic signed [3:0] p);
		int bi;
		int s;
		int b;
		logic [TAG_WIDTH-1:0] t;
		// negative or out-of-range providers train nothing
		if (p < 0 || p > NUM_BANKS)
			return;
		if (p == 0) begin
			bi = base_index(a);
			if (!base_v[bi]) begin
				base_v[bi] = 1'b1;
				base_d[bi] = v;
				base_c[bi] = '0;
				return;
			end
			base_d[bi] = v;
			base_c[bi] = ok ? sat_up(base_c[bi]) : sat_down(base_c[bi]);
			return;
		end
		b = int'(p) - 1;
		s = bank_index(a, b);
		t = bank_tag(a, b);
		if (!tag_v[s] || tag_t[s] != t) begin
			fill_entry(s, t, v);
			return;
		end
		tag_d[s] = v;
		if (ok) begin
			tag_c[s] = sat_up(tag_c[s]);
			if (tag_u[s] != USEFUL_MAX)
				tag_u[s] = tag_u[s] + 2'd1;
		end else begin
			tag_c[s] = sat_down(tag_c[s]);
			tag_u[s] = '0;
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_t w;
		if (!arst_n) begin
			for (int i = 0; i < BASE_DEPTH; i++)
				base_v[i] = 1'b0;
			for (int i = 0; i < TAG_DEPTH; i++)
				tag_v[i] = 1'b0;
			path         = '0;
			threshold    = 3'd7;
			hist_len     = 7'd64;
			errors       = 0;
			pending      = 0;
			results_seen = 0;
			lookups_due.delete();
		end else begin
			if (result_valid) begin
				results_seen++;
				if (lookups_due.size() == 0) begin
					report("unexpected result", predicted_value, 64'd0);
				end else begin
					w = lookups_due.pop_front();
					if (available !== w.avail)
						report("available", 64'(available), 64'(w.avail));
					if (confident !== w.conf)
						report("confident", 64'(confident), 64'(w.conf));
					if (predicted_value !== w.value)
						report("predicted_value", predicted_value, w.value);
					if (provider_out !== w.prov)
						report("provider_out", 64'(provider_out), 64'(w.prov));
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_THRESHOLD)
					threshold = pwdata[2:0];
				else if (paddr == ADDR_HIST_LEN)
					hist_len = pwdata[6:0];
			end
			if (start && !busy) begin
				case (mode_t'(mode))
					MODE_PREDICT:    lookups_due.push_back(lookup(pc));
					MODE_TRAIN:      learn(pc, actual_value);
					MODE_TRAIN_PROV: learn_provider(pc, actual_value, was_correct, provider_in);
					default: begin
						path = {path[62:0], pc[2] ^ branch_taken};
						if (hist_len < 7'd64)
							path = path & ((64'd1 << hist_len) - 64'd1);
					end
				endcase
			end
			pending = lookups_due.size();
		end
	end

endmodule

/* test/tb_vtage_value_predictor.sv */
`timescale 1ns / 100ps
// tb_vtage_value_predictor: stimulus and verdict for the value predictor
// depends on vtp_pkg, vtage_value_predictor and vtp_checker
module tb_vtage_value_predictor;
	import vtp_pkg::*;

	localparam logic [2:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
	localparam logic [2:0] ADDR_HIST_LEN  = {REG_HIST_LEN, 2'b00};
	localparam int SETTLE = 200;   // longer than one full transaction

	typedef struct packed {
		mode_t             mode;
		logic [63:0]       pc;
		logic [63:0]       value;
		logic              ok;
		logic signed [3:0] prov;
		logic              taken;
	} op_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        mode = '0;
	logic [63:0]       pc = '0;
	logic [63:0]       actual_value = '0;
	logic              was_correct = 1'b0;
	logic signed [3:0] provider_in = '0;
	logic              branch_taken = 1'b0;
	logic              result_valid;
	logic              available;
	logic              confident;
	logic [63:0]       predicted_value;
	logic signed [3:0] provider_out;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                errors;
	int                pending;
	int                results_seen;
	int                sent = 0;

	// small pools so that repeated pcs and values build up confidence and tag hits
	logic [63:0] pc_pool  [12];
	logic [63:0] val_pool [6];

	always #2 clk = ~clk;

	vtage_value_predictor uut (
		.clk, .arst_n, .start, .busy, .mode, .pc, .actual_value, .was_correct,
		.provider_in, .branch_taken, .result_valid, .available, .confident,
		.predicted_value, .provider_out, .psel, .penable, .pwrite, .paddr,
		.pwdata, .prdata, .pready
	);

	vtp_checker chk (
		.clk, .arst_n, .start, .busy, .mode, .pc, .actual_value, .was_correct,
		.provider_in, .branch_taken, .result_valid, .available, .confident,
		.predicted_value, .provider_out, .psel, .penable, .pwrite, .pready,
		.paddr, .pwdata, .errors, .pending, .results_seen
	);

	// one transaction: optional gap, then hold start until it is taken
	task automatic send(input op_t op, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start        <= 1'b1;
		mode         <= op.mode;
		pc           <= op.pc;
		actual_value <= op.value;
		was_correct  <= op.ok;
		provider_in  <= op.prov;
		branch_taken <= op.taken;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);
		// train and path transactions leave no result behind, so give them time
		repeat (SETTLE) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic op_t make_op(input mode_t m, input logic [63:0] a, input logic [63:0] v,
			input logic ok, input logic signed [3:0] p, input logic tk);
		return '{mode: m, pc: a, value: v, ok: ok, prov: p, taken: tk};
	endfunction

	function automatic op_t rand_op();
		op_t o;
		int r;
		r = $urandom_range(0, 99);
		o.mode  = (r < 30) ? MODE_PREDICT : (r < 65) ? MODE_TRAIN :
			(r < 85) ? MODE_TRAIN_PROV : MODE_PATH;
		o.pc    = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
			pc_pool[$urandom_range(0, 11)];
		o.value = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom} :
			val_pool[$urandom_range(0, 5)];
		o.ok    = 1'($urandom_range(0, 1));
		o.prov  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(0, 5)) - 4'sd1;
		o.taken = 1'($urandom_range(0, 1));
		return o;
	endfunction

	initial begin
		#3_000_000;
		$display("[vtage_value_predictor] ERROR");
		$finish;
	end

	initial begin
		logic [31:0] thr_set [6];
		logic [31:0] len_set [6];
		logic [63:0] ones;
		thr_set = '{32'd7, 32'd0, 32'd3, 32'd1, 32'd7, 32'd4};
		len_set = '{32'd64, 32'd0, 32'd3, 32'd8, 32'd127, 32'd17};
		ones = '1;
		foreach (pc_pool[i])
			pc_pool[i] = {$urandom, $urandom};
		foreach (val_pool[i])
			val_pool[i] = {$urandom, $urandom};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every mode, negative and oversized providers
		send(make_op(MODE_PREDICT, 64'd0, 64'd0, 1'b0, PROV_NONE, 1'b0), 0);
		send(make_op(MODE_TRAIN, 64'd0, 64'd0, 1'b0, PROV_NONE, 1'b0), 0);
		send(make_op(MODE_PREDICT, 64'd0, 64'd0, 1'b0, PROV_NONE, 1'b0), 1);
		send(make_op(MODE_TRAIN, ones, ones, 1'b1, PROV_NONE, 1'b1), 0);
		send(make_op(MODE_TRAIN, ones, ones, 1'b1, PROV_NONE, 1'b1), 0);
		send(make_op(MODE_PREDICT, ones, 64'd0, 1'b0, PROV_NONE, 1'b0), 3);
		for (int k = 0; k < 6; k++)
			send(make_op(MODE_TRAIN, pc_pool[0], val_pool[0], 1'b0, PROV_NONE, 1'b0), 0);
		send(make_op(MODE_PREDICT, pc_pool[0], 64'd0, 1'b0, PROV_NONE, 1'b0), 0);
		send(make_op(MODE_TRAIN_PROV, pc_pool[0], val_pool[1], 1'b1, 4'sd4, 1'b0), 0);
		send(make_op(MODE_TRAIN_PROV, pc_pool[0], val_pool[1], 1'b0, 4'sd0, 1'b0), 0);
		send(make_op(MODE_TRAIN_PROV, pc_pool[0], val_pool[2], 1'b1, -4'sd8, 1'b0), 0);
		send(make_op(MODE_TRAIN_PROV, pc_pool[0], val_pool[2], 1'b1, 4'sd5, 1'b0), 0);
		send(make_op(MODE_TRAIN_PROV, pc_pool[0], val_pool[2], 1'b1, 4'sd7, 1'b0), 0);
		send(make_op(MODE_PREDICT, pc_pool[0], 64'd0, 1'b0, PROV_NONE, 1'b0), 0);
		send(make_op(MODE_PATH, 64'd4, 64'd0, 1'b0, PROV_NONE, 1'b0), 0);
		send(make_op(MODE_PATH, 64'd0, 64'd0, 1'b0, PROV_NONE, 1'b1), 2);
		send(make_op(MODE_PATH, ones, 64'd0, 1'b0, PROV_NONE, 1'b1), 0);
		send(make_op(MODE_PREDICT, pc_pool[0], 64'd0, 1'b0, PROV_NONE, 1'b0), 0);

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			go_idle();
			apb_write(ADDR_THRESHOLD, thr_set[ph]);
			apb_write(ADDR_HIST_LEN, len_set[ph]);
			for (int n = 0; n < 150; n++)
				send(rand_op(), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
		end

		go_idle();
		$display("sent %0d transactions over 6 register settings, %0d predictions checked",
			sent, results_seen);
		if (errors == 0) begin
			$display("[vtage_value_predictor] OK");
		end else begin
			$display("[vtage_value_predictor] ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/vtp_pkg.sv
hdl/vtp_ram.sv
hdl/vtp_hash.sv
hdl/vtage_value_predictor.sv
test/vtp_checker.sv
test/tb_vtage_value_predictor.sv
